[rtl/tcaq_pkg.sv]
// Package for the two-class admission queue.
// Holds sizes, operation and status codes, the sequencer state type and helpers.
// Depends on nothing.
`timescale 1ns / 1ps

package tcaq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QADDR_W     = $clog2(QUEUE_DEPTH);
  localparam int LEN_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int USER_W      = 8;
  localparam int SLOT_W      = 8;
  localparam int CNT_W       = 32;
  localparam int LIMIT_W     = 8;
  localparam int AHEAD_W     = 6;
  localparam int STATUS_W    = 3;
  localparam int OP_W        = 2;

  localparam logic [SLOT_W-1:0]  SLOT_MAX  = '1;
  localparam logic [CNT_W-1:0]   CNT_MAX   = '1;
  localparam logic [LEN_W-1:0]   LEN_FULL  = LEN_W'(QUEUE_DEPTH);

  localparam logic [LIMIT_W-1:0] ORD_LIMIT_RST  = LIMIT_W'(8);
  localparam logic [LIMIT_W-1:0] PRIO_LIMIT_RST = LIMIT_W'(16);

  localparam logic REG_ORD_LIMIT  = 1'b0;
  localparam logic REG_PRIO_LIMIT = 1'b1;

  localparam logic [OP_W-1:0] OP_REQUEST  = 2'd0;
  localparam logic [OP_W-1:0] OP_RELEASE  = 2'd1;
  localparam logic [OP_W-1:0] OP_WITHDRAW = 2'd2;

  localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_REL_ERROR = 3'd3;
  localparam logic [STATUS_W-1:0] ST_WITHDRAWN = 3'd4;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd5;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd6;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR
  } seq_state_t;

  function automatic logic fits(input logic [SLOT_W-1:0] act,
                                input logic [LIMIT_W-1:0] limit);
    return (act < limit) && (act < SLOT_MAX);
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

endpackage

[rtl/tcaq_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module tcaq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/two_class_admission_queue.sv]
// Top level of the two-class admission queue: sequencer, counters, FIFO pointers.
// Depends on tcaq_pkg and tcaq_ram (one RAM per class FIFO).
//
//   channel   handshake        payload
//   ------    ---------------  ---------------------------------------------------
//   event in  start / busy     op, user_id, is_priority
//   result    done (1 cycle)   status, ahead_count, grant_*, active_slots, *_total
//   config    cfg_we           cfg_addr, cfg_wdata
//
// Request and unknown op: done in the cycle after accept. Release: likewise, or
// via S_POP if a waiter is granted. Withdraw: S_SRCH_RD, S_SRCH_CMP per entry, then
// S_SHIFT_RD/S_SHIFT_WR per shifted entry, bounded by the single FIFO RAM read port.
// rst is synchronous and clears control state; FIFO contents are not cleared.
// The receiver cannot stall: each result is shown for exactly the done cycle.
`timescale 1ns / 1ps

module two_class_admission_queue (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  output logic                               done,
  input  logic [tcaq_pkg::OP_W-1:0]          op,
  input  logic [tcaq_pkg::USER_W-1:0]        user_id,
  input  logic                               is_priority,
  output logic [tcaq_pkg::STATUS_W-1:0]      status,
  output logic [tcaq_pkg::AHEAD_W-1:0]       ahead_count,
  output logic                               grant_valid,
  output logic [tcaq_pkg::USER_W-1:0]        grant_user,
  output logic                               grant_priority,
  output logic [tcaq_pkg::SLOT_W-1:0]        active_slots,
  output logic [tcaq_pkg::CNT_W-1:0]         total_requests,
  output logic [tcaq_pkg::CNT_W-1:0]         withdrawn_total,
  output logic [tcaq_pkg::CNT_W-1:0]         granted_total,
  input  logic                               cfg_we,
  input  logic                               cfg_addr,
  input  logic [tcaq_pkg::LIMIT_W-1:0]       cfg_wdata
);

  tcaq_pkg::seq_state_t state, state_next;

  logic [tcaq_pkg::LIMIT_W-1:0]  ordinary_limit, priority_limit;
  logic [tcaq_pkg::SLOT_W-1:0]   active_count, active_count_next;
  logic [tcaq_pkg::QADDR_W-1:0]  p_head, p_head_next, o_head, o_head_next;
  logic [tcaq_pkg::LEN_W-1:0]    p_len, p_len_next, o_len, o_len_next;
  logic [tcaq_pkg::CNT_W-1:0]    req_cnt, req_cnt_next;
  logic [tcaq_pkg::CNT_W-1:0]    wd_cnt, wd_cnt_next;
  logic [tcaq_pkg::CNT_W-1:0]    gr_cnt, gr_cnt_next;
  logic [tcaq_pkg::USER_W-1:0]   user_q, user_q_next;
  logic                          cls_q, cls_q_next;
  logic [tcaq_pkg::LEN_W-1:0]    idx, idx_next;
  logic                          done_next;
  logic [tcaq_pkg::STATUS_W-1:0] status_next;
  logic [tcaq_pkg::AHEAD_W-1:0]  ahead_next;
  logic                          gvalid_next, gprio_next;
  logic [tcaq_pkg::USER_W-1:0]   guser_next;

  logic                          p_we, o_we;
  logic [tcaq_pkg::QADDR_W-1:0]  waddr, raddr;
  logic [tcaq_pkg::USER_W-1:0]   wdata, p_rdata, o_rdata, rd_data;
  logic [tcaq_pkg::QADDR_W-1:0]  head_cur;
  logic [tcaq_pkg::LEN_W-1:0]    len_cur, idx_inc;
  logic [tcaq_pkg::SLOT_W-1:0]   act_dec;

  tcaq_ram #(.WIDTH(tcaq_pkg::USER_W), .DEPTH(tcaq_pkg::QUEUE_DEPTH)) u_prio_ram (
    .clk   (clk),
    .we    (p_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (p_rdata)
  );

  tcaq_ram #(.WIDTH(tcaq_pkg::USER_W), .DEPTH(tcaq_pkg::QUEUE_DEPTH)) u_ord_ram (
    .clk   (clk),
    .we    (o_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (o_rdata)
  );

  assign busy            = (state != tcaq_pkg::S_IDLE);
  assign active_slots    = active_count;
  assign total_requests  = req_cnt;
  assign withdrawn_total = wd_cnt;
  assign granted_total   = gr_cnt;

  assign rd_data  = cls_q ? p_rdata : o_rdata;
  assign head_cur = cls_q ? p_head : o_head;
  assign len_cur  = cls_q ? p_len : o_len;
  assign idx_inc  = idx + tcaq_pkg::LEN_W'(1);
  assign act_dec  = active_count - tcaq_pkg::SLOT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= tcaq_pkg::S_IDLE;
      ordinary_limit <= tcaq_pkg::ORD_LIMIT_RST;
      priority_limit <= tcaq_pkg::PRIO_LIMIT_RST;
      active_count   <= '0;
      p_head         <= '0;
      o_head         <= '0;
      p_len          <= '0;
      o_len          <= '0;
      req_cnt        <= '0;
      wd_cnt         <= '0;
      gr_cnt         <= '0;
      done           <= 1'b0;
    end else begin
      state        <= state_next;
      active_count <= active_count_next;
      p_head       <= p_head_next;
      o_head       <= o_head_next;
      p_len        <= p_len_next;
      o_len        <= o_len_next;
      req_cnt      <= req_cnt_next;
      wd_cnt       <= wd_cnt_next;
      gr_cnt       <= gr_cnt_next;
      done         <= done_next;
      if (cfg_we) begin
        if (cfg_addr == tcaq_pkg::REG_ORD_LIMIT) begin
          ordinary_limit <= cfg_wdata;
        end else begin
          priority_limit <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    user_q         <= user_q_next;
    cls_q          <= cls_q_next;
    idx            <= idx_next;
    status         <= status_next;
    ahead_count    <= ahead_next;
    grant_valid    <= gvalid_next;
    grant_user     <= guser_next;
    grant_priority <= gprio_next;
  end

  always_comb begin
    state_next        = state;
    active_count_next = active_count;
    p_head_next       = p_head;
    o_head_next       = o_head;
    p_len_next        = p_len;
    o_len_next        = o_len;
    req_cnt_next      = req_cnt;
    wd_cnt_next       = wd_cnt;
    gr_cnt_next       = gr_cnt;
    user_q_next       = user_q;
    cls_q_next        = cls_q;
    idx_next          = idx;
    done_next         = 1'b0;
    status_next       = status;
    ahead_next        = ahead_count;
    gvalid_next       = grant_valid;
    guser_next        = grant_user;
    gprio_next        = grant_priority;
    p_we              = 1'b0;
    o_we              = 1'b0;
    waddr             = head_cur + idx[tcaq_pkg::QADDR_W-1:0];
    wdata             = rd_data;
    raddr             = head_cur + idx[tcaq_pkg::QADDR_W-1:0];

    unique case (state)
      tcaq_pkg::S_IDLE: begin
        if (start) begin
          user_q_next = user_id;
          cls_q_next  = is_priority;
          idx_next    = '0;
          ahead_next  = '0;
          gvalid_next = 1'b0;
          guser_next  = '0;
          gprio_next  = 1'b0;
          status_next = tcaq_pkg::ST_REL_ERROR;
          done_next   = 1'b1;
          case (op)
            tcaq_pkg::OP_REQUEST: begin
              req_cnt_next = tcaq_pkg::sat_inc(req_cnt);
              wdata        = user_id;
              if (is_priority ? tcaq_pkg::fits(active_count, priority_limit)
                              : tcaq_pkg::fits(active_count, ordinary_limit)) begin
                active_count_next = active_count + tcaq_pkg::SLOT_W'(1);
                gr_cnt_next       = tcaq_pkg::sat_inc(gr_cnt);
                status_next       = tcaq_pkg::ST_GRANTED;
              end else if (is_priority) begin
                if (p_len == tcaq_pkg::LEN_FULL) begin
                  status_next = tcaq_pkg::ST_FULL;
                end else begin
                  p_we        = 1'b1;
                  waddr       = p_head + p_len[tcaq_pkg::QADDR_W-1:0];
                  p_len_next  = p_len + tcaq_pkg::LEN_W'(1);
                  ahead_next  = tcaq_pkg::AHEAD_W'(p_len);
                  status_next = tcaq_pkg::ST_QUEUED;
                end
              end else begin
                if (o_len == tcaq_pkg::LEN_FULL) begin
                  status_next = tcaq_pkg::ST_FULL;
                end else begin
                  o_we        = 1'b1;
                  waddr       = o_head + o_len[tcaq_pkg::QADDR_W-1:0];
                  o_len_next  = o_len + tcaq_pkg::LEN_W'(1);
                  ahead_next  = tcaq_pkg::AHEAD_W'(p_len) + tcaq_pkg::AHEAD_W'(o_len);
                  status_next = tcaq_pkg::ST_QUEUED;
                end
              end
            end
            tcaq_pkg::OP_RELEASE: begin
              if (active_count != '0) begin
                active_count_next = act_dec;
                status_next       = tcaq_pkg::ST_RELEASED;
                if (p_len != '0 && tcaq_pkg::fits(act_dec, priority_limit)) begin
                  raddr      = p_head;
                  cls_q_next = 1'b1;
                  done_next  = 1'b0;
                  state_next = tcaq_pkg::S_POP;
                end else if (p_len == '0 && o_len != '0
                             && tcaq_pkg::fits(act_dec, ordinary_limit)) begin
                  raddr      = o_head;
                  cls_q_next = 1'b0;
                  done_next  = 1'b0;
                  state_next = tcaq_pkg::S_POP;
                end
              end
            end
            tcaq_pkg::OP_WITHDRAW: begin
              done_next  = 1'b0;
              state_next = tcaq_pkg::S_SRCH_RD;
            end
            default: begin
            end
          endcase
        end
      end

      tcaq_pkg::S_POP: begin
        gvalid_next       = 1'b1;
        guser_next        = rd_data;
        gprio_next        = cls_q;
        active_count_next = active_count + tcaq_pkg::SLOT_W'(1);
        gr_cnt_next       = tcaq_pkg::sat_inc(gr_cnt);
        if (cls_q) begin
          p_head_next = p_head + tcaq_pkg::QADDR_W'(1);
          p_len_next  = p_len - tcaq_pkg::LEN_W'(1);
        end else begin
          o_head_next = o_head + tcaq_pkg::QADDR_W'(1);
          o_len_next  = o_len - tcaq_pkg::LEN_W'(1);
        end
        done_next  = 1'b1;
        state_next = tcaq_pkg::S_IDLE;
      end

      tcaq_pkg::S_SRCH_RD: begin
        if (idx == len_cur) begin
          status_next = tcaq_pkg::ST_NOT_FOUND;
          done_next   = 1'b1;
          state_next  = tcaq_pkg::S_IDLE;
        end else begin
          state_next = tcaq_pkg::S_SRCH_CMP;
        end
      end

      tcaq_pkg::S_SRCH_CMP: begin
        if (rd_data == user_q) begin
          state_next = tcaq_pkg::S_SHIFT_RD;
        end else begin
          idx_next   = idx_inc;
          state_next = tcaq_pkg::S_SRCH_RD;
        end
      end

      tcaq_pkg::S_SHIFT_RD: begin
        raddr = head_cur + idx_inc[tcaq_pkg::QADDR_W-1:0];
        if (idx_inc >= len_cur) begin
          if (cls_q) begin
            p_len_next = p_len - tcaq_pkg::LEN_W'(1);
          end else begin
            o_len_next = o_len - tcaq_pkg::LEN_W'(1);
          end
          wd_cnt_next = tcaq_pkg::sat_inc(wd_cnt);
          status_next = tcaq_pkg::ST_WITHDRAWN;
          done_next   = 1'b1;
          state_next  = tcaq_pkg::S_IDLE;
        end else begin
          state_next = tcaq_pkg::S_SHIFT_WR;
        end
      end

      tcaq_pkg::S_SHIFT_WR: begin
        p_we       = cls_q;
        o_we       = !cls_q;
        idx_next   = idx_inc;
        state_next = tcaq_pkg::S_SHIFT_RD;
      end

      default: begin
        state_next = tcaq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/tcaq_chk.sv]
// Port-level checker for the two-class admission queue, bound to the top level.
// Depends on tcaq_pkg.
`timescale 1ns / 1ps

module tcaq_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [tcaq_pkg::OP_W-1:0]     op,
  input logic [tcaq_pkg::STATUS_W-1:0] status,
  input logic [tcaq_pkg::AHEAD_W-1:0]  ahead_count,
  input logic                          grant_valid
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while sequencer busy");

  a_req_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == tcaq_pkg::OP_REQUEST) |=> (done && !busy))
    else $error("request item did not finish in one cycle");

  a_grant_on_release: assert property (@(posedge clk) disable iff (rst)
    (done && grant_valid) |-> (status == tcaq_pkg::ST_RELEASED))
    else $error("waiter grant outside a release");

  a_ahead_queued: assert property (@(posedge clk) disable iff (rst)
    (done && status != tcaq_pkg::ST_QUEUED) |-> (ahead_count == '0))
    else $error("ahead count set on a non-queued result");

endmodule

bind two_class_admission_queue tcaq_chk u_tcaq_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .op          (op),
  .status      (status),
  .ahead_count (ahead_count),
  .grant_valid (grant_valid)
);
